### sv/fcln_pkg.sv
package fcln_pkg;

  localparam int LANES  = 4;
  localparam int DATA_W = 32;
  // Sum of four squared 32-bit magnitudes needs 65 bits.
  localparam int SUM_W  = 65;
  // Square root of a 65-bit value, one root bit per stage.
  localparam int ROOT_W = 33;

  typedef logic [LANES-1:0][DATA_W-1:0] vec_t;

  typedef struct packed {
    logic op;    // normalize this word
    logic zero;  // normalize found a zero-length vector
  } ctl_t;

  localparam int PAY_W = $bits(vec_t) + $bits(ctl_t);

endpackage

### sv/four_component_lerp_normalize.sv
// Channel   Dir  tdata                                         tuser
// s_*       in   start_0..3, end_0..3, weight (288 bits)         op
// m_*       out  out_0..3 (128 bits)                             zero_length
//
// A word passes the lane stages, the pair sums, the total, the square root and the dividers
// to the output register; one word is taken per cycle unless the output stalls the pipeline.
// Most of the depth lies in the 33-stage square root and the FRAC_BITS+1 stage dividers.
// Reset is synchronous and clears only the valid bits of the pipeline.
// The pipeline moves as a whole whenever the output register is empty or taken.
// While the output waits, an input word is still taken into an empty first stage.
module four_component_lerp_normalize import fcln_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // start_0, start_1, start_2, start_3, end_0, end_1, end_2, end_3, weight
  input  logic [287:0] s_tdata,
  // op
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_0, out_1, out_2, out_3
  output logic [127:0] m_tdata,
  // zero_length
  output logic         m_tuser
);

  // Stage map: lanes 0..3, pair sums 4, total 5, square root 6..38,
  // dividers 39..39+FRAC_BITS, output register last.
  localparam int LANE_LAT = 4;
  localparam int DEPTH    = 41 + FRAC_BITS;
  localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

  logic [DEPTH-1:0] vld;
  logic             en;
  logic             ld0;

  assign en       = !vld[DEPTH-1] || m_tready;
  assign s_tready = en || !vld[0];
  assign ld0      = s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld0) begin
        vld[0] <= s_tvalid;
      end
      if (en) begin
        vld[DEPTH-1:1] <= vld[DEPTH-2:0];
      end
    end
  end

  // Mode bit travels beside the lanes.
  logic op_p [0:LANE_LAT-1];

  always_ff @(posedge clk) begin
    if (ld0) begin
      op_p[0] <= s_tuser;
    end
    if (en) begin
      for (int i = 1; i < LANE_LAT; i++) begin
        op_p[i] <= op_p[i-1];
      end
    end
  end

  vec_t              v_d;
  logic [2*DATA_W-1:0] sq_d [0:LANES-1];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    fcln_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk       (clk),
      .ld        (ld0),
      .en        (en),
      .start_val (s_tdata[DATA_W*i +: DATA_W]),
      .end_val   (s_tdata[DATA_W*(LANES+i) +: DATA_W]),
      .weight    (s_tdata[DATA_W*2*LANES +: DATA_W]),
      .v         (v_d[i]),
      .sq        (sq_d[i])
    );
  end

  // Merge: the squares of the four lanes are summed over two stages.
  logic [SUM_W-1:0] s01, s23, sum_f;
  vec_t             v_e, v_f;
  logic             op_e;
  ctl_t             ctl_f;

  always_ff @(posedge clk) begin
    if (en) begin
      s01   <= SUM_W'(sq_d[0]) + SUM_W'(sq_d[1]);
      s23   <= SUM_W'(sq_d[2]) + SUM_W'(sq_d[3]);
      v_e   <= v_d;
      op_e  <= op_p[LANE_LAT-1];
      sum_f <= s01 + s23;
      v_f   <= v_e;
      ctl_f.op   <= op_e;
      ctl_f.zero <= op_e && (v_e == '0);
    end
  end

  logic [ROOT_W-1:0] root;
  logic [PAY_W-1:0]  pay_sq;
  vec_t              v_sq;
  ctl_t              ctl_sq;

  fcln_isqrt u_isqrt (
    .clk     (clk),
    .en      (en),
    .sum     (sum_f),
    .pay_in  ({ctl_f, v_f}),
    .root    (root),
    .pay_out (pay_sq)
  );

  assign {ctl_sq, v_sq} = pay_sq;

  // Control word is delayed alongside the dividers.
  ctl_t ctl_d [1:FRAC_BITS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_d[1] <= ctl_sq;
      for (int k = 2; k <= FRAC_BITS + 1; k++) begin
        ctl_d[k] <= ctl_d[k-1];
      end
    end
  end

  vec_t norm, v_dv, out_r;
  logic zero_r;

  for (genvar i = 0; i < LANES; i++) begin : g_div
    fcln_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk   (clk),
      .en    (en),
      .v     (v_sq[i]),
      .root  (root),
      .norm  (norm[i]),
      .v_out (v_dv[i])
    );
  end

  // Output register: plain interpolation, normalized vector, or identity.
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r <= ctl_d[FRAC_BITS+1].zero;
      for (int i = 0; i < LANES; i++) begin
        if (ctl_d[FRAC_BITS+1].zero) begin
          out_r[i] <= (i == LANES - 1) ? ONE : '0;
        end else if (ctl_d[FRAC_BITS+1].op) begin
          out_r[i] <= norm[i];
        end else begin
          out_r[i] <= v_dv[i];
        end
      end
    end
  end

  assign m_tvalid = vld[DEPTH-1];
  assign m_tdata  = out_r;
  assign m_tuser  = zero_r;

endmodule

### sv/fcln_lane.sv
module fcln_lane import fcln_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              ld,
  input  logic              en,
  input  logic [DATA_W-1:0] start_val,
  input  logic [DATA_W-1:0] end_val,
  input  logic [DATA_W-1:0] weight,
  output logic [DATA_W-1:0] v,
  output logic [2*DATA_W-1:0] sq
);

  localparam int PW = DATA_W + 1 + FRAC_BITS + 2;
  localparam logic [DATA_W-1:0] ONE32 = DATA_W'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  logic [DATA_W-1:0]   s_a;
  logic [DATA_W:0]     d_a;
  logic [FRAC_BITS:0]  w_a;
  logic [FRAC_BITS:0]  w_clamp;
  logic [DATA_W-1:0]   s_b;
  logic signed [PW-1:0] p_b;
  logic signed [PW-1:0] p_adj;
  logic signed [PW-1:0] p_sh;
  logic [DATA_W-1:0]   v_c;
  logic [DATA_W-1:0]   mag;

  // Weight is clamped to the range zero to one.
  always_comb begin
    if (weight[DATA_W-1]) begin
      w_clamp = '0;
    end else if (weight > ONE32) begin
      w_clamp = ONE;
    end else begin
      w_clamp = weight[FRAC_BITS:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      s_a <= start_val;
      d_a <= {end_val[DATA_W-1], end_val} - {start_val[DATA_W-1], start_val};
      w_a <= w_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_b <= s_a;
      p_b <= PW'($signed(d_a) * $signed({1'b0, w_a}));
    end
  end

  // Truncate toward zero: bias negative products before the arithmetic shift.
  assign p_adj = p_b[PW-1] ? p_b + PW'((1 << FRAC_BITS) - 1) : p_b;
  assign p_sh  = p_adj >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      v_c <= s_b + p_sh[DATA_W-1:0];
    end
  end

  assign mag = v_c[DATA_W-1] ? (~v_c + DATA_W'(1)) : v_c;

  always_ff @(posedge clk) begin
    if (en) begin
      v  <= v_c;
      sq <= mag * mag;
    end
  end

endmodule

### sv/fcln_isqrt.sv
module fcln_isqrt import fcln_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SUM_W-1:0]  sum,
  input  logic [PAY_W-1:0]  pay_in,
  output logic [ROOT_W-1:0] root,
  output logic [PAY_W-1:0]  pay_out
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 1;

  logic [RAD_W-1:0]  rad  [0:ROOT_W];
  logic [REM_W-1:0]  rem  [0:ROOT_W];
  logic [ROOT_W-1:0] rt   [0:ROOT_W];
  logic [PAY_W-1:0]  pay  [0:ROOT_W];

  assign rad[0] = {{(RAD_W-SUM_W){1'b0}}, sum};
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign pay[0] = pay_in;

  // Digit-by-digit square root: two radicand bits in, one root bit out per stage.
  for (genvar j = 0; j < ROOT_W; j++) begin : g_step
    logic [REM_W+1:0] x;
    logic [REM_W+1:0] trial;
    logic             ge;

    assign x     = {rem[j], rad[j][RAD_W-1 -: 2]};
    assign trial = (REM_W+2)'({rt[j], 2'b01});
    assign ge    = (x >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rad[j+1] <= rad[j] << 2;
        rem[j+1] <= ge ? REM_W'(x - trial) : REM_W'(x);
        rt[j+1]  <= {rt[j][ROOT_W-2:0], ge};
        pay[j+1] <= pay[j];
      end
    end
  end

  assign root    = rt[ROOT_W];
  assign pay_out = pay[ROOT_W];

endmodule

### sv/fcln_div_lane.sv
module fcln_div_lane import fcln_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              en,
  input  logic [DATA_W-1:0] v,
  input  logic [ROOT_W-1:0] root,
  output logic [DATA_W-1:0] norm,
  output logic [DATA_W-1:0] v_out
);

  localparam int STG = FRAC_BITS + 1;
  localparam int RW  = ROOT_W + 1;

  logic [RW-1:0]     rr [0:STG];
  logic [FRAC_BITS:0] q [0:STG];
  logic [ROOT_W-1:0] lr [0:STG];
  logic [DATA_W-1:0] vv [0:STG];
  logic [DATA_W-1:0] mag;

  assign mag   = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
  assign rr[0] = RW'(mag);
  assign q[0]  = '0;
  assign lr[0] = root;
  assign vv[0] = v;

  // Restoring division of |v| * ONE by the length, one quotient bit per stage.
  // The magnitude never exceeds the length, so the quotient has FRAC_BITS+1 bits.
  for (genvar k = 0; k < STG; k++) begin : g_step
    logic [RW-1:0] x;
    logic          ge;

    if (k == 0) begin : g_first
      assign x = rr[0];
    end else begin : g_next
      assign x = {rr[k][RW-2:0], 1'b0};
    end

    assign ge = (x >= RW'(lr[k]));

    always_ff @(posedge clk) begin
      if (en) begin
        rr[k+1] <= ge ? x - RW'(lr[k]) : x;
        q[k+1]  <= {q[k][FRAC_BITS-1:0], ge};
        lr[k+1] <= lr[k];
        vv[k+1] <= vv[k];
      end
    end
  end

  assign norm  = vv[STG][DATA_W-1] ? (~DATA_W'(q[STG]) + DATA_W'(1)) : DATA_W'(q[STG]);
  assign v_out = vv[STG];

endmodule

### sv/fcln_checker.sv
module fcln_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [287:0] s_tdata,
  input logic         s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata,
  input logic         m_tuser
);

  localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

  a_in_known: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> !$isunknown({s_tdata, s_tuser}))
    else $error("input word taken with unknown bits");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  a_identity: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[127:96] == ONE && m_tdata[95:0] == 96'd0)
    else $error("zero-length flag without identity vector");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output register empty");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind four_component_lerp_normalize fcln_checker #(.FRAC_BITS(FRAC_BITS)) u_fcln_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

### dv/tb_four_component_lerp_normalize.sv
`timescale 1ns / 100ps

module tb_four_component_lerp_normalize;
  import fcln_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam int OP_LERP = 0;
  localparam int OP_NLERP = 1;
  localparam int WORDS_PER_PHASE = 215;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES = 300;

  // One input word: mode plus two vectors and a weight.
  typedef struct {
    bit op;
    int st[LANES];
    int en[LANES];
    int wt;
  } lerp_word_t;

  // One output word as the block should produce it.
  typedef struct {
    int o[LANES];
    bit zero;
  } lerp_result_t;

  class lerp_scoreboard;
    lerp_result_t expected_q[$];
    int errors;

    // Clamp, interpolate per lane, then optionally scale to unit length.
    static function lerp_result_t predict(lerp_word_t w);
      lerp_result_t r;
      longint wt, s, e, v[LANES];
      logic [67:0] sum, cc;
      logic [33:0] root, cand;
      longint mag;
      wt = w.wt;
      if (wt < 0) wt = 0;
      if (wt > ONE) wt = ONE;
      for (int i = 0; i < LANES; i++) begin
        s = w.st[i];
        e = w.en[i];
        v[i] = s + ((e - s) * wt) / ONE;
      end
      r.zero = 0;
      if (w.op == OP_NLERP) begin
        sum = '0;
        for (int i = 0; i < LANES; i++) begin
          mag = (v[i] < 0) ? -v[i] : v[i];
          sum = sum + 68'(mag) * 68'(mag);
        end
        if (sum == 0) begin
          v[0] = 0; v[1] = 0; v[2] = 0; v[3] = ONE;
          r.zero = 1;
        end else begin
          // Bitwise integer square root, floor of the exact value.
          root = '0;
          for (int b = 32; b >= 0; b--) begin
            cand = root | (34'(1) << b);
            cc = 68'(cand) * 68'(cand);
            if (cc <= sum) root = cand;
          end
          for (int i = 0; i < LANES; i++)
            v[i] = (v[i] * ONE) / longint'(root);
        end
      end
      for (int i = 0; i < LANES; i++) r.o[i] = int'(v[i]);
      return r;
    endfunction

    function void note_input(lerp_word_t w);
      expected_q = {expected_q, predict(w)};
    endfunction

    function void check_result(logic [127:0] data, logic zero);
      lerp_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word out: data=%h zero_length=%b", $time, data, zero);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      for (int i = 0; i < LANES; i++)
        if (data[i*DATA_W +: DATA_W] !== exp_r.o[i]) begin
          $display("%0t: out_%0d expected %h actual %h", $time, i, exp_r.o[i],
                   data[i*DATA_W +: DATA_W]);
          errors++;
        end
      if (zero !== exp_r.zero) begin
        $display("%0t: zero_length expected %b actual %b", $time, exp_r.zero, zero);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [287:0] s_tdata;   // start_0..3, end_0..3, weight from the low bits up
  logic         s_tuser;   // op
  logic         m_tvalid;
  logic         m_tready;
  logic [127:0] m_tdata;   // out_0..3 from the low bits up
  logic         m_tuser;   // zero_length

  lerp_scoreboard sb;
  int  tx_idle_pct;
  int  rx_idle_pct;
  bit  hold_req;
  int  hold_count;

  four_component_lerp_normalize #(.FRAC_BITS(FRAC_BITS)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Receiver: random back-pressure, plus a long hold-off on request so the
  // pipeline fills and the input stalls while words keep being offered.
  always @(posedge clk) begin
    if (hold_req && hold_count == 0) hold_count <= HOLD_CYCLES;
    if (hold_count > 1 || (hold_req && hold_count == 0)) begin
      m_tready <= 1'b0;
      if (hold_count > 0) hold_count <= hold_count - 1;
    end else begin
      if (hold_count == 1) hold_count <= 0;
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Output words are sampled at the edge where the handshake completes.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  // Offer one word, idling first at random, and return once it is taken.
  task automatic send_word(lerp_word_t w);
    logic [287:0] packed_data;
    for (int i = 0; i < LANES; i++) begin
      packed_data[i*32 +: 32] = w.st[i];
      packed_data[(i+4)*32 +: 32] = w.en[i];
    end
    packed_data[256 +: 32] = w.wt;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= packed_data;
    s_tuser  <= w.op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(w);
  endtask

  // Components drawn from a mix of full range, small Q16.16 values and extremes.
  function automatic int rand_comp();
    case ($urandom_range(9))
      0, 1, 2: return $urandom;
      3:       return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      4:       return 0;
      5:       return int'($urandom_range(7)) - 3;
      default: return int'($urandom_range(6 * 65536)) - 3 * 65536;
    endcase
  endfunction

  function automatic int rand_weight();
    case ($urandom_range(7))
      0:       return $urandom;
      1:       return -int'($urandom_range(100000));
      2:       return 65536 + $urandom_range(100000);
      3:       return $urandom_range(1) ? 0 : 65536;
      default: return $urandom_range(65536);
    endcase
  endfunction

  function automatic lerp_word_t rand_word();
    lerp_word_t w;
    w.op = $urandom_range(1);
    w.wt = rand_weight();
    for (int i = 0; i < LANES; i++) begin
      w.st[i] = rand_comp();
      w.en[i] = rand_comp();
    end
    // Now and then a vector that interpolates to zero length.
    if ($urandom_range(19) == 0)
      for (int i = 0; i < LANES; i++) begin
        w.st[i] = 0;
        w.en[i] = $urandom_range(1) ? 0 : w.en[i];
        if (w.en[i] != 0) w.wt = 0;
      end
    return w;
  endfunction

  function automatic lerp_word_t make_word(bit op, int s, int e, int wt);
    lerp_word_t w;
    w.op = op;
    w.wt = wt;
    for (int i = 0; i < LANES; i++) begin
      w.st[i] = s;
      w.en[i] = e;
    end
    return w;
  endfunction

  initial begin
    lerp_word_t w;
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    hold_req = 1'b0;
    hold_count = 0;
    tx_idle_pct = 7;
    rx_idle_pct = 88;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words: weight clamping, range extremes, zero length, both modes.
    for (int op = OP_LERP; op <= OP_NLERP; op++) begin
      send_word(make_word(op, 0, 0, 32768));
      send_word(make_word(op, 32'h80000000, 32'h7fffffff, 65536));
      send_word(make_word(op, 32'h7fffffff, 32'h80000000, 32768));
      send_word(make_word(op, 32'h80000000, 32'h7fffffff, 32'h80000000));
      send_word(make_word(op, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
      send_word(make_word(op, 65536, -65536, 1));
      send_word(make_word(op, -3, 5, 65535));
      send_word(make_word(op, 1, 1, -1));
      send_word(make_word(op, -1, -1, 65537));
    end
    w = make_word(OP_NLERP, 0, 0, 0);
    w.st[3] = 65536;
    send_word(w);
    w.st[3] = -1;
    w.st[0] = 32'h80000000;
    send_word(w);

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 88 : 0;
      rx_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 7 : 0;
      if (phase == 2) hold_req = 1'b1;
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (n == 20) hold_req = 1'b0;
        send_word(rand_word());
      end
    end
    s_tvalid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_four_component_lerp_normalize: PASS");
    end else begin
      $display("tb_four_component_lerp_normalize: FAIL");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("tb_four_component_lerp_normalize: FAIL");
    $finish;
  end

endmodule
